// File: src/i2cw_pkg.sv
// Shared types and constants for the write-only I2C master.
// Used by the front end, the command queue, the bus engine and the top level.
package i2cw_pkg;

    // Function codes on the input channel
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_DATA  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam int PHASE_TICKS_W        = 16;
    localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = 16'd50;

    // Depth of the queue between front end and bus engine
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int BIT_IDX_W      = 4;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_TICK,
        CMD_NOP
    } cmd_kind_t;

    // Classified item as it travels through the queue
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] payload;
        logic       stop;
        logic       sda;
    } cmd_t;

    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_START,
        BUS_BIT,
        BUS_ACK,
        BUS_WAIT,
        BUS_STOP
    } bus_state_t;

endpackage

// File: src/i2c_master_byte_writer.sv
// Write-only I2C bus master, top level.
// Depends on i2cw_pkg, i2cw_front, i2cw_cmd_fifo and i2cw_engine.
//
// Every item (start with address, data byte, or one time tick) yields one
// result with the SCL/SDA levels and status after that item. The block takes
// one item per clock cycle sustained while results are taken: the item is
// decoded into a two-entry command queue, the bus engine applies one
// command per cycle and writes the result into an output register. A
// stalled result register stalls the engine, and the queue then fills
// before s_ready drops. Each SCL bit spends four phases of phase_ticks
// tick items; phase_ticks is written through cfg_wr_en and cfg_wr_data.
// The user must write it only while the block is idle; the block itself
// does not enforce this.
module i2c_master_byte_writer import i2cw_pkg::*; #(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [PHASE_TICKS_W-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_func,
    input  logic [6:0]               s_target_address,
    input  logic [7:0]               s_data_byte,
    input  logic                     s_stop_after,
    input  logic                     s_sda_line,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_scl_level,
    output logic                     m_sda_level,
    output logic                     m_byte_acked,
    output logic                     m_no_ack_error,
    output logic                     m_ready_for_byte,
    output logic                     m_idle
);

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_valid;
    logic queue_ready;

    // Decode the incoming item
    i2cw_front u_front (
        .func           (s_func),
        .target_address (s_target_address),
        .data_byte      (s_data_byte),
        .stop_after     (s_stop_after),
        .sda_line       (s_sda_line),
        .cmd            (front_cmd)
    );

    // Queue decoded commands
    i2cw_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    // Run the bus sequence
    i2cw_engine #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .cmd_valid        (queue_valid),
        .cmd_ready        (queue_ready),
        .cmd              (queue_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_scl_level      (m_scl_level),
        .m_sda_level      (m_sda_level),
        .m_byte_acked     (m_byte_acked),
        .m_no_ack_error   (m_no_ack_error),
        .m_ready_for_byte (m_ready_for_byte),
        .m_idle           (m_idle)
    );

endmodule

// File: src/i2cw_front.sv
// Front end: decodes the function code of each incoming item into a command.
// Depends on i2cw_pkg for the function codes and the command type.
module i2cw_front import i2cw_pkg::*; (
    input  logic [1:0] func,
    input  logic [6:0] target_address,
    input  logic [7:0] data_byte,
    input  logic       stop_after,
    input  logic       sda_line,
    output cmd_t       cmd
);

    // Classify the item and pick the byte to shift out
    always_comb begin
        cmd.stop = stop_after;
        cmd.sda  = sda_line;
        case (func)
            FUNC_START: begin
                cmd.kind    = CMD_START;
                cmd.payload = {target_address, 1'b0};
            end
            FUNC_DATA: begin
                cmd.kind    = CMD_DATA;
                cmd.payload = data_byte;
            end
            FUNC_TICK: begin
                cmd.kind    = CMD_TICK;
                cmd.payload = 8'd0;
            end
            default: begin
                cmd.kind    = CMD_NOP;
                cmd.payload = 8'd0;
            end
        endcase
    end

endmodule

// File: src/i2cw_cmd_fifo.sv
// Short command queue that decouples the front end from the bus engine.
// Depends on i2cw_pkg for the command type and the queue depth.
module i2cw_cmd_fifo import i2cw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_FIFO_DEPTH);

    cmd_t             fifo_mem [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = fifo_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            fifo_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/i2cw_engine.sv
// Bus engine: runs the I2C write sequence one command per cycle unless stalled
// and holds the result in an output register. Depends on i2cw_pkg for states and commands.
module i2cw_engine import i2cw_pkg::*; #(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [PHASE_TICKS_W-1:0] cfg_wr_data,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  cmd_t                     cmd,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_scl_level,
    output logic                     m_sda_level,
    output logic                     m_byte_acked,
    output logic                     m_no_ack_error,
    output logic                     m_ready_for_byte,
    output logic                     m_idle
);

    // Wide enough for the phase length and for the counter cap
    localparam int LIM_W = ((TICK_COUNT_WIDTH > PHASE_TICKS_W) ?
                            TICK_COUNT_WIDTH : PHASE_TICKS_W) + 1;
    localparam logic [LIM_W-1:0] TICK_CAP = LIM_W'(1) << TICK_COUNT_WIDTH;

    logic [PHASE_TICKS_W-1:0]    phase_ticks_reg;
    bus_state_t                  state_reg, state_next;
    logic [BIT_IDX_W-1:0]        bit_idx_reg, bit_idx_next;
    logic [7:0]                  shift_reg, shift_next;
    logic [TICK_COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [1:0]                  quarter_reg, quarter_next;
    logic                        stop_pend_reg, stop_pend_next;

    logic                        out_valid_reg;
    logic                        scl_reg, sda_reg, acked_reg, nack_reg, rfb_reg, idle_reg;
    logic                        scl_next, sda_next, acked_next, nack_next;

    logic                        out_free, pop, busy, tick_last;
    logic [LIM_W-1:0]            lim_raw, lim;
    logic [BIT_IDX_W-1:0]        bit_inc;

    assign out_free  = !out_valid_reg || m_ready;
    assign cmd_ready = out_free;
    assign pop       = cmd_valid && out_free;
    assign busy      = state_reg inside {BUS_START, BUS_BIT, BUS_ACK, BUS_STOP};
    assign bit_inc   = bit_idx_reg + BIT_IDX_W'(1);

    // Phase length: zero counts as one, capped by the counter range
    always_comb begin
        lim_raw = LIM_W'(phase_ticks_reg);
        if (phase_ticks_reg == '0) begin
            lim = LIM_W'(1);
        end else if (lim_raw > TICK_CAP) begin
            lim = TICK_CAP;
        end else begin
            lim = lim_raw;
        end
        tick_last = (LIM_W'(tick_reg) + LIM_W'(1)) >= lim;
    end

    // Next state of the bus sequencer
    always_comb begin
        state_next     = state_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        quarter_next   = quarter_reg;
        stop_pend_next = stop_pend_reg;
        acked_next     = 1'b0;
        nack_next      = 1'b0;
        if (pop) begin
            case (cmd.kind)
                CMD_START: begin
                    if (!busy) begin
                        state_next     = BUS_START;
                        shift_next     = cmd.payload;
                        bit_idx_next   = '0;
                        quarter_next   = 2'd0;
                        tick_next      = '0;
                        stop_pend_next = cmd.stop;
                    end
                end
                CMD_DATA: begin
                    if (state_reg == BUS_WAIT) begin
                        state_next     = BUS_BIT;
                        shift_next     = cmd.payload;
                        bit_idx_next   = '0;
                        quarter_next   = 2'd0;
                        tick_next      = '0;
                        stop_pend_next = cmd.stop;
                    end
                end
                CMD_TICK: begin
                    if (busy) begin
                        if (!tick_last) begin
                            tick_next = tick_reg + TICK_COUNT_WIDTH'(1);
                        end else begin
                            tick_next = '0;
                            case (state_reg)
                                BUS_START: begin
                                    if (quarter_reg != 2'd3) begin
                                        quarter_next = quarter_reg + 2'd1;
                                    end else begin
                                        state_next   = BUS_BIT;
                                        bit_idx_next = '0;
                                        quarter_next = 2'd0;
                                    end
                                end
                                BUS_BIT: begin
                                    if (quarter_reg != 2'd3) begin
                                        quarter_next = quarter_reg + 2'd1;
                                    end else begin
                                        quarter_next = 2'd0;
                                        shift_next   = {shift_reg[6:0], 1'b0};
                                        bit_idx_next = bit_inc;
                                        if (bit_inc >= BIT_IDX_W'(8)) begin
                                            state_next   = BUS_ACK;
                                            bit_idx_next = '0;
                                        end
                                    end
                                end
                                BUS_ACK: begin
                                    if (quarter_reg == 2'd2) begin
                                        if (cmd.sda) begin
                                            // Missing ack: abort with a stop
                                            nack_next      = 1'b1;
                                            stop_pend_next = 1'b0;
                                            state_next     = BUS_STOP;
                                            bit_idx_next   = '0;
                                            quarter_next   = 2'd0;
                                        end else begin
                                            acked_next   = 1'b1;
                                            quarter_next = 2'd3;
                                        end
                                    end else if (quarter_reg == 2'd3) begin
                                        quarter_next   = 2'd0;
                                        state_next     = stop_pend_reg ? BUS_STOP : BUS_WAIT;
                                        stop_pend_next = 1'b0;
                                    end else begin
                                        quarter_next = quarter_reg + 2'd1;
                                    end
                                end
                                BUS_STOP: begin
                                    if (quarter_reg != 2'd3) begin
                                        quarter_next = quarter_reg + 2'd1;
                                    end else begin
                                        state_next   = BUS_IDLE;
                                        shift_next   = 8'd0;
                                        bit_idx_next = '0;
                                        quarter_next = 2'd0;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Line levels after the update
    always_comb begin
        case (state_next)
            BUS_START: begin
                scl_next = (quarter_next == 2'd0) || (quarter_next == 2'd1);
                sda_next = (quarter_next == 2'd0);
            end
            BUS_BIT: begin
                scl_next = (quarter_next == 2'd1) || (quarter_next == 2'd2);
                sda_next = shift_next[7];
            end
            BUS_ACK: begin
                scl_next = (quarter_next == 2'd1) || (quarter_next == 2'd2);
                sda_next = 1'b1;
            end
            BUS_WAIT: begin
                scl_next = 1'b0;
                sda_next = 1'b0;
            end
            BUS_STOP: begin
                scl_next = (quarter_next != 2'd0);
                sda_next = (quarter_next == 2'd2) || (quarter_next == 2'd3);
            end
            default: begin
                scl_next = 1'b1;
                sda_next = 1'b1;
            end
        endcase
    end

    // Sequencer and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            state_reg       <= BUS_IDLE;
            bit_idx_reg     <= '0;
            shift_reg       <= 8'd0;
            tick_reg        <= '0;
            quarter_reg     <= 2'd0;
            stop_pend_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                phase_ticks_reg <= cfg_wr_data;
            end
            state_reg     <= state_next;
            bit_idx_reg   <= bit_idx_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            quarter_reg   <= quarter_next;
            stop_pend_reg <= stop_pend_next;
        end
    end

    // Output register: hold until taken, load on each processed command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            acked_reg <= acked_next;
            nack_reg  <= nack_next;
            rfb_reg   <= (state_next == BUS_WAIT);
            idle_reg  <= (state_next == BUS_IDLE);
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_scl_level      = scl_reg;
    assign m_sda_level      = sda_reg;
    assign m_byte_acked     = acked_reg;
    assign m_no_ack_error   = nack_reg;
    assign m_ready_for_byte = rfb_reg;
    assign m_idle           = idle_reg;

endmodule

// File: src/i2cw_checker.sv
// Port-level checks for the write-only I2C master, bound to the top level.
// Depends only on the top level's ports.
module i2cw_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_scl_level,
    input logic m_sda_level,
    input logic m_byte_acked,
    input logic m_no_ack_error,
    input logic m_ready_for_byte,
    input logic m_idle
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Never ack and nack the same byte
    a_ack_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_byte_acked && m_no_ack_error))
        else $error("ack and missing ack together");

    // Waiting for a byte is not a free bus
    a_wait_idle_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_idle && m_ready_for_byte))
        else $error("idle while waiting for byte");

    // A free bus has both lines released
    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_idle |-> m_scl_level && m_sda_level)
        else $error("bus lines driven while idle");

    // While waiting, hold both lines low
    a_wait_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready_for_byte |-> !m_scl_level && !m_sda_level)
        else $error("bus lines released while waiting");

endmodule

bind i2c_master_byte_writer i2cw_checker u_i2cw_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_scl_level      (m_scl_level),
    .m_sda_level      (m_sda_level),
    .m_byte_acked     (m_byte_acked),
    .m_no_ack_error   (m_no_ack_error),
    .m_ready_for_byte (m_ready_for_byte),
    .m_idle           (m_idle)
);

// File: test/i2c_master_byte_writer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the write-only I2C master: drives start, data, tick and noise items,
// predicts SCL/SDA and status per item, and checks every result. Depends on i2cw_pkg and the RTL.
module i2c_master_byte_writer_test;
    import i2cw_pkg::*;

    // Unused function code; the block must ignore it
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int PRINT_LIMIT   = 20;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] addr;
        logic [7:0] dbyte;
        logic       stop;
        logic       sda;
    } bus_cmd_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic acked;
        logic no_ack;
        logic wait_byte;
        logic bus_free;
    } line_status_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [PHASE_TICKS_W-1:0] cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_func = '0;
    logic [6:0]               s_target_address = '0;
    logic [7:0]               s_data_byte = '0;
    logic                     s_stop_after = 1'b0;
    logic                     s_sda_line = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_scl_level;
    logic                     m_sda_level;
    logic                     m_byte_acked;
    logic                     m_no_ack_error;
    logic                     m_ready_for_byte;
    logic                     m_idle;

    i2c_master_byte_writer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_target_address (s_target_address),
        .s_data_byte      (s_data_byte),
        .s_stop_after     (s_stop_after),
        .s_sda_line       (s_sda_line),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_scl_level      (m_scl_level),
        .m_sda_level      (m_sda_level),
        .m_byte_acked     (m_byte_acked),
        .m_no_ack_error   (m_no_ack_error),
        .m_ready_for_byte (m_ready_for_byte),
        .m_idle           (m_idle)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    bus_cmd_t     pending_items[$];
    line_status_t status_expect_q[$];

    int error_count     = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int acks_seen       = 0;
    int nacks_seen      = 0;
    bit bus_waiting     = 1'b0;

    // Shadow copy of the bus engine
    logic [PHASE_TICKS_W-1:0] phase_ticks = PHASE_TICKS_RESET;
    bus_state_t               bus_st = BUS_IDLE;
    logic [3:0]               bit_idx = '0;
    logic [7:0]               shreg = '0;
    int unsigned              tick_cnt = 0;
    logic [1:0]               quarter = '0;
    logic                     stop_pend = 1'b0;

    task automatic flag_error(input string msg);
        if (error_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void load_phase(input bus_state_t st, input logic [7:0] value);
        bus_st   = st;
        shreg    = value;
        bit_idx  = '0;
        quarter  = '0;
        tick_cnt = 0;
    endfunction

    // Advance the shadow engine by one item and return the line levels after it
    function automatic line_status_t step_bus(input logic [1:0] func, input logic [6:0] addr,
                                              input logic [7:0] dbyte, input logic stop_in,
                                              input logic sda_in);
        line_status_t r;
        logic         busy;
        int unsigned  lim;
        r    = '0;
        busy = bus_st inside {BUS_START, BUS_BIT, BUS_ACK, BUS_STOP};
        lim  = (phase_ticks == 0) ? 1 : 32'(phase_ticks);
        if (func == FUNC_START && !busy) begin
            load_phase(BUS_START, {addr, 1'b0});
            stop_pend = stop_in;
        end else if (func == FUNC_DATA && bus_st == BUS_WAIT) begin
            load_phase(BUS_BIT, dbyte);
            stop_pend = stop_in;
        end else if (func == FUNC_TICK && busy) begin
            if (tick_cnt + 1 < lim) begin
                tick_cnt++;
            end else begin
                // end of a quarter phase
                tick_cnt = 0;
                case (bus_st)
                    BUS_START: begin
                        if (quarter < 3) quarter++;
                        else load_phase(BUS_BIT, shreg);
                    end
                    BUS_BIT: begin
                        if (quarter < 3) begin
                            quarter++;
                        end else begin
                            quarter = '0;
                            shreg   = shreg << 1;
                            bit_idx = bit_idx + 1'b1;
                            if (bit_idx >= 8) begin
                                bus_st  = BUS_ACK;
                                bit_idx = '0;
                            end
                        end
                    end
                    BUS_ACK: begin
                        if (quarter == 2) begin
                            if (sda_in) begin
                                r.no_ack  = 1'b1;
                                stop_pend = 1'b0;
                                load_phase(BUS_STOP, shreg);
                            end else begin
                                r.acked = 1'b1;
                                quarter = 2'd3;
                            end
                        end else if (quarter == 3) begin
                            quarter   = '0;
                            bus_st    = stop_pend ? BUS_STOP : BUS_WAIT;
                            stop_pend = 1'b0;
                        end else begin
                            quarter++;
                        end
                    end
                    BUS_STOP: begin
                        if (quarter < 3) quarter++;
                        else load_phase(BUS_IDLE, 8'h00);
                    end
                    default: ;
                endcase
            end
        end

        case (bus_st)
            BUS_START: begin r.scl = (quarter < 2);  r.sda = (quarter == 0); end
            BUS_BIT:   begin r.scl = (quarter == 1 || quarter == 2); r.sda = shreg[7]; end
            BUS_ACK:   begin r.scl = (quarter == 1 || quarter == 2); r.sda = 1'b1; end
            BUS_WAIT:  begin r.scl = 1'b0; r.sda = 1'b0; end
            BUS_STOP:  begin r.scl = (quarter != 0); r.sda = (quarter >= 2); end
            default:   begin r.scl = 1'b1; r.sda = 1'b1; end
        endcase
        r.wait_byte = (bus_st == BUS_WAIT);
        r.bus_free  = (bus_st == BUS_IDLE);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus builders

    task automatic push_item(input logic [1:0] func, input logic [6:0] addr,
                             input logic [7:0] dbyte, input logic stop, input logic sda);
        bus_cmd_t c;
        c.func  = func;
        c.addr  = addr;
        c.dbyte = dbyte;
        c.stop  = stop;
        c.sda   = sda;
        pending_items.push_back(c);
    endtask

    // Ticks with random SDA, sprinkled with commands the busy engine must drop
    task automatic push_ticks(input int n);
        logic [1:0] f;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 2))
                    0:       f = FUNC_START;
                    1:       f = FUNC_DATA;
                    default: f = FUNC_NONE;
                endcase
                push_item(f, 7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
            push_item(FUNC_TICK, 7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // Items with no effect while the bus is free or waiting for a byte
    task automatic push_quiet_noise;
        int         n;
        logic [1:0] f;
        n = $urandom_range(0, 3);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0:       f = FUNC_TICK;
                1:       f = FUNC_NONE;
                default: f = bus_waiting ? FUNC_TICK : FUNC_DATA;
            endcase
            push_item(f, 7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // One address or data byte, clocked out through its ack and any stop
    task automatic queue_byte(input bit is_start, input logic [7:0] value, input bit stop_f,
                              input bit nack, input int pt);
        if (is_start) begin
            push_item(FUNC_START, value[6:0], 8'($urandom), stop_f, 1'($urandom));
            push_ticks(4 * pt);
        end else begin
            push_item(FUNC_DATA, 7'($urandom), value, stop_f, 1'($urandom));
        end
        // eight bits, two ack quarters and all but the last tick of the third, then the tick that samples the ack
        push_ticks(35 * pt - 1);
        push_item(FUNC_TICK, 7'($urandom), 8'($urandom), 1'($urandom), nack);
        push_ticks(nack ? 4 * pt : (stop_f ? 5 * pt : pt));
        bus_waiting = !nack && !stop_f;
        push_quiet_noise();
    endtask

    // A message of an address and up to three bytes, some with repeated starts
    task automatic queue_message(input int pt, input bit allow_hang);
        int nbytes;
        bit last;
        bit nack;
        bit stop_f;
        nbytes = $urandom_range(0, 3);
        for (int k = 0; k <= nbytes; k++) begin
            last   = (k == nbytes);
            nack   = ($urandom_range(0, 7) == 0);
            stop_f = last && (!allow_hang || $urandom_range(0, 3) != 0);
            queue_byte(k == 0 || $urandom_range(0, 4) == 0, 8'($urandom), stop_f, nack, pt);
            if (!bus_waiting) return;
        end
    endtask

    task automatic queue_random(input int pt, input int count);
        while (pending_items.size() < count) queue_message(pt, 1'b1);
        // leave the bus free for the next register write
        if (bus_waiting) queue_message(pt, 1'b0);
        while (bus_waiting) queue_message(pt, 1'b0);
    endtask

    task automatic wait_drained;
        while (pending_items.size() != 0 || s_valid || status_expect_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_phase_ticks(input logic [PHASE_TICKS_W-1:0] value);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        phase_ticks = value;
        @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- sender

    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive_items
        bus_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // predict the item taken at this edge
            if (s_valid && s_ready) begin
                status_expect_q.push_back(step_bus(s_func, s_target_address, s_data_byte,
                                                   s_stop_after, s_sda_line));
                items_taken++;
            end
            // hold until accepted, then advance or idle
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    s_func           <= nxt.func;
                    s_target_address <= nxt.addr;
                    s_data_byte      <= nxt.dbyte;
                    s_stop_after     <= nxt.stop;
                    s_sda_line       <= nxt.sda;
                    s_valid          <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver and checker

    logic [7:0] stall_pat = 8'hFF;
    logic [4:0] stall_pos = '0;

    always @(posedge aclk) begin : check_results
        line_status_t got;
        line_status_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.scl       = m_scl_level;
                got.sda       = m_sda_level;
                got.acked     = m_byte_acked;
                got.no_ack    = m_no_ack_error;
                got.wait_byte = m_ready_for_byte;
                got.bus_free  = m_idle;
                if (status_expect_q.size() == 0) begin
                    flag_error($sformatf("result %6b with no item outstanding", got));
                end else begin
                    want = status_expect_q.pop_front();
                    acks_seen  += want.acked;
                    nacks_seen += want.no_ack;
                    if (got !== want)
                        flag_error($sformatf({"result %0d: scl/sda/acked/nack/wait/idle ",
                                              "got %6b, expected %6b"},
                                             results_checked, got, want));
                end
                results_checked++;
            end
            // pick a new stall pattern each time stall_pos wraps; some windows never stall
            stall_pos = stall_pos + 1'b1;
            if (stall_pos == 0)
                stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            m_ready <= stall_pat[stall_pos[2:0]];
        end
    end

    // Drop out if neither channel moves for too long
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("i2c_master_byte_writer_test: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset setting: the free bus ignores ticks, data and the unused code
        push_item(FUNC_TICK, 7'h7F, 8'hFF, 1'b1, 1'b1);
        push_item(FUNC_DATA, 7'h00, 8'hFF, 1'b1, 1'b0);
        push_item(FUNC_NONE, 7'h7F, 8'h00, 1'b0, 1'b1);

        // directed messages at the fastest bit rate
        write_phase_ticks(16'd1);
        queue_byte(1'b1, 8'h7F, 1'b0, 1'b0, 1);   // top address, acked, stays open
        queue_byte(1'b0, 8'hFF, 1'b0, 1'b0, 1);
        queue_byte(1'b0, 8'h00, 1'b0, 1'b0, 1);
        queue_byte(1'b1, 8'h00, 1'b0, 1'b0, 1);   // repeated start to address zero
        queue_byte(1'b0, 8'hA5, 1'b1, 1'b0, 1);   // last byte with stop
        queue_byte(1'b1, 8'h55, 1'b0, 1'b1, 1);   // address not acked
        queue_byte(1'b1, 8'h2A, 1'b0, 1'b0, 1);
        queue_byte(1'b0, 8'h5A, 1'b1, 1'b1, 1);   // data not acked despite stop request
        queue_byte(1'b1, 8'h33, 1'b1, 1'b0, 1);   // stop right after the address
        queue_random(1, 550);

        // zero behaves as one tick per phase
        write_phase_ticks(16'd0);
        queue_random(1, 200);

        write_phase_ticks(16'd2);
        queue_random(2, 350);

        write_phase_ticks(16'd3);
        queue_random(3, 300);

        // longest phase: only the opening of a start condition fits in the run
        write_phase_ticks(16'hFFFF);
        push_item(FUNC_START, 7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        push_ticks(120);

        wait_drained();
        $display("summary: %0d items driven, %0d results checked", items_taken, results_checked);
        $display("summary: %0d acked bytes, %0d missing acks, phase_ticks 50/1/0/2/3/65535",
                 acks_seen, nacks_seen);
        if (error_count == 0) begin
            $display("i2c_master_byte_writer_test: clean");
        end else begin
            $display("i2c_master_byte_writer_test: errors");
        end
        $finish;
    end

endmodule
